@@ rtl/http_chunked_body_decoder_defines.svh @@
// assertion macros for the chunked body decoder
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define HCBD_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hcbd assertion failed");

// next-cycle implication, disabled during reset
`define HCBD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hcbd assertion failed");

`endif

@@ rtl/hcbd_pkg.sv @@
// types, character constants and hex decode for the chunked body decoder
package hcbd_pkg;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;
  localparam logic [7:0] CH_SP = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       size_saturated;
  } out_item_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t h;
    h.valid = 1'b0;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.valid = 1'b1;
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.valid = 1'b1;
      h.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.valid = 1'b1;
      h.value = 4'(b - 8'h37);
    end
    return h;
  endfunction

endpackage

@@ rtl/hcbd_stream_if.sv @@
// valid/ready stream channel carrying one item of type T
interface hcbd_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/http_chunked_body_decoder.sv @@
// chunked transfer body decoder: header pass-through, chunk framing removal
//
// rx carries one request byte per item with in_last on the final byte.
// tx carries decoded bytes: the header through its blank line, then the
// chunk data bytes, then a CR LF CR LF terminator whose last byte has
// out_last set. size_saturated reports a chunk size clamped to SIZE_BITS.
// each rx item is held in a two-entry input stage (main plus skid), parsed
// combinationally and its results written to a result group register.
// an accepted rx item passes the main entry, then the group register, to tx.
// throughput: one rx item per cycle while each item gives at most one
// result and tx is ready; an item that ends the message gives up to five
// results, one per cycle as tx takes them; the input stage waits for the last.
// rx.ready comes straight from the skid register, so a stalled tx fills
// the group register, then the main and skid entries, then drops ready.
// reset clears the parser to header scanning and empties all stages.
module http_chunked_body_decoder
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  hcbd_stream_if.sink            rx,
  hcbd_stream_if.source          tx
);

  `include "http_chunked_body_decoder_defines.svh"

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SIZE   = 3'd1;
  localparam logic [2:0] PH_EXT    = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam logic [2:0] POS_BYTE  = 3'd0;
  localparam logic [2:0] POS_CR1   = 3'd1;
  localparam logic [2:0] POS_LF1   = 3'd2;
  localparam logic [2:0] POS_CR2   = 3'd3;
  localparam logic [2:0] POS_LF2   = 3'd4;

  // input stage
  logic     a_valid, s_valid;
  in_item_t a_item, s_item;

  // parser state
  logic [2:0]           phase, phase_next;
  logic [1:0]           tmatch, tmatch_next;
  logic [SIZE_BITS-1:0] acc, acc_next;
  logic                 seen, seen_next;
  logic [SIZE_BITS-1:0] rem, rem_next;
  logic [1:0]           skip, skip_next;
  logic                 sat, sat_next;

  // result group
  logic       g_valid;
  logic       g_has;
  logic       g_term;
  logic       g_sat;
  logic [7:0] g_byte;
  logic [2:0] pos;

  logic       has_byte, term, sat_upd;
  hex_digit_t hv;
  logic       rx_fire, tx_fire, g_final, g_free, take;
  logic [7:0] b;

  assign b       = a_item.in_byte;
  assign hv      = hex_decode(b);
  assign rx.ready = ~s_valid;
  assign rx_fire = rx.valid & rx.ready;
  assign tx_fire = tx.valid & tx.ready;
  assign g_final = (pos == POS_LF2) || (pos == POS_BYTE && !g_term);
  assign g_free  = !g_valid || (tx.ready && g_final);
  assign take    = a_valid && (g_free || !(has_byte || term));

  always_comb begin
    phase_next  = phase;
    tmatch_next = tmatch;
    acc_next    = acc;
    seen_next   = seen;
    rem_next    = rem;
    skip_next   = skip;
    sat_upd     = sat;
    has_byte    = 1'b0;
    term        = 1'b0;
    unique case (phase)
      PH_HEADER: begin
        has_byte = 1'b1;
        if (tmatch == 2'd3 && b == CH_LF) begin
          tmatch_next = 2'd0;
          phase_next  = PH_SIZE;
          acc_next    = '0;
          seen_next   = 1'b0;
        end else if (b == CH_CR) begin
          tmatch_next = (tmatch == 2'd2) ? 2'd3 : 2'd1;
        end else if (b == CH_LF && tmatch == 2'd1) begin
          tmatch_next = 2'd2;
        end else begin
          tmatch_next = 2'd0;
        end
      end
      PH_SIZE: begin
        if (hv.valid) begin
          if (acc[SIZE_BITS-1 -: 4] != 4'd0) begin
            acc_next = '1;
            sat_upd  = 1'b1;
          end else begin
            acc_next = {acc[SIZE_BITS-5:0], hv.value};
          end
          seen_next = 1'b1;
        end else if (b == CH_SP && !seen) begin
          phase_next = PH_SIZE;
        end else if (acc == '0) begin
          term       = 1'b1;
          phase_next = PH_DONE;
        end else begin
          rem_next   = acc;
          phase_next = (b == CH_LF) ? PH_DATA : PH_EXT;
        end
      end
      PH_EXT: begin
        if (b == CH_LF) begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        has_byte = 1'b1;
        rem_next = rem - SIZE_BITS'(1);
        if (rem == SIZE_BITS'(1)) begin
          phase_next = PH_SKIP;
          skip_next  = 2'd2;
        end
      end
      PH_SKIP: begin
        skip_next = skip - 2'd1;
        if (skip == 2'd1) begin
          phase_next = PH_SIZE;
          acc_next   = '0;
          seen_next  = 1'b0;
        end
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_HEADER;
      end
    endcase
    sat_next = sat_upd;
    if (a_item.in_last) begin
      term        = term || (phase != PH_DONE);
      phase_next  = PH_HEADER;
      tmatch_next = 2'd0;
      acc_next    = '0;
      seen_next   = 1'b0;
      rem_next    = '0;
      skip_next   = 2'd0;
      sat_next    = 1'b0;
    end
  end

  // input stage with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      s_valid <= 1'b0;
    end else if (take) begin
      if (s_valid) begin
        a_item  <= s_item;
        s_valid <= 1'b0;
      end else if (rx_fire) begin
        a_item  <= rx.data;
      end else begin
        a_valid <= 1'b0;
      end
    end else if (rx_fire) begin
      if (!a_valid) begin
        a_item  <= rx.data;
        a_valid <= 1'b1;
      end else begin
        s_item  <= rx.data;
        s_valid <= 1'b1;
      end
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HEADER;
      tmatch <= 2'd0;
      acc    <= '0;
      seen   <= 1'b0;
      rem    <= '0;
      skip   <= 2'd0;
      sat    <= 1'b0;
    end else if (take) begin
      phase  <= phase_next;
      tmatch <= tmatch_next;
      acc    <= acc_next;
      seen   <= seen_next;
      rem    <= rem_next;
      skip   <= skip_next;
      sat    <= sat_next;
    end
  end

  // result group and output sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
      pos     <= POS_BYTE;
    end else if (take && (has_byte || term)) begin
      g_valid <= 1'b1;
      g_has   <= has_byte;
      g_term  <= term;
      g_sat   <= sat_upd;
      g_byte  <= b;
      pos     <= has_byte ? POS_BYTE : POS_CR1;
    end else if (tx_fire) begin
      if (g_final) begin
        g_valid <= 1'b0;
      end else begin
        pos <= pos + 3'd1;
      end
    end
  end

  assign tx.valid = g_valid;

  always_comb begin
    tx.data.size_saturated = g_sat;
    tx.data.out_last       = (pos == POS_LF2);
    unique case (pos)
      POS_BYTE: tx.data.out_byte = g_byte;
      POS_CR1:  tx.data.out_byte = CH_CR;
      POS_LF1:  tx.data.out_byte = CH_LF;
      POS_CR2:  tx.data.out_byte = CH_CR;
      POS_LF2:  tx.data.out_byte = CH_LF;
      default:  tx.data.out_byte = CH_LF;
    endcase
  end

  `HCBD_ASSERT_IMPL(a_skid_implies_main, clk, rst, s_valid, a_valid)
  `HCBD_ASSERT_IMPL(a_data_has_bytes, clk, rst, phase == PH_DATA, rem != '0)
  `HCBD_ASSERT_IMPL(a_skip_nonzero, clk, rst, phase == PH_SKIP, skip != 2'd0)
  `HCBD_ASSERT_IMPL(a_group_byte_pos, clk, rst, g_valid && pos == POS_BYTE, g_has)
  `HCBD_ASSERT_NEXT(a_last_empties, clk, rst,
    tx_fire && tx.data.out_last && !(take && (has_byte || term)), !g_valid)

endmodule

@@ test/http_chunked_body_decoder_checker.sv @@
// checker for the chunked body decoder: predicts decoded tx items from rx items and compares
module http_chunked_body_decoder_checker
  import hcbd_pkg::*;
#(
  parameter int SIZE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      rx_valid,
  input  logic      rx_ready,
  input  in_item_t  rx_data,
  input  logic      tx_valid,
  input  logic      tx_ready,
  input  out_item_t tx_data,
  output int        failures,
  output int        outstanding
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SIZE,
    PH_EXT,
    PH_DATA,
    PH_SKIP,
    PH_DONE
  } parse_phase_t;

  localparam logic [63:0] SIZE_MAX = {64{1'b1}} >> (64 - SIZE_BITS);

  parse_phase_t phase;
  logic [1:0]   crlf_seen;
  logic [63:0]  chunk_size;
  logic         digit_seen;
  logic [63:0]  data_left;
  logic [1:0]   pair_left;
  logic         clamped;
  out_item_t    decoded_q[$];

  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return {1'b1, 4'(b - "0")};
    if (b >= "a" && b <= "f") return {1'b1, 4'(b - "a" + 8'd10)};
    if (b >= "A" && b <= "F") return {1'b1, 4'(b - "A" + 8'd10)};
    return 5'd0;
  endfunction

  task automatic put(input logic [7:0] b, input logic last);
    out_item_t o;
    o.out_byte       = b;
    o.out_last       = last;
    o.size_saturated = clamped;
    decoded_q.push_back(o);
  endtask

  task automatic clear_state();
    phase      = PH_HEADER;
    crlf_seen  = 2'd0;
    chunk_size = '0;
    digit_seen = 1'b0;
    data_left  = '0;
    pair_left  = 2'd0;
    clamped    = 1'b0;
  endtask

  task automatic new_size_line();
    phase      = PH_SIZE;
    chunk_size = '0;
    digit_seen = 1'b0;
  endtask

  task automatic close_message(input logic request_end);
    put(CH_CR, 1'b0);
    put(CH_LF, 1'b0);
    put(CH_CR, 1'b0);
    put(CH_LF, 1'b1);
    if (request_end) clear_state();
    else phase = PH_DONE;
  endtask

  task automatic decode_byte(input in_item_t it);
    logic [7:0] b;
    logic [4:0] nib;
    b = it.in_byte;
    case (phase)
      PH_HEADER: begin
        put(b, 1'b0);
        if (crlf_seen == 2'd3 && b == CH_LF) begin
          crlf_seen = 2'd0;
          new_size_line();
        end else if (b == CH_CR) begin
          crlf_seen = (crlf_seen == 2'd2) ? 2'd3 : 2'd1;
        end else if (b == CH_LF && crlf_seen == 2'd1) begin
          crlf_seen = 2'd2;
        end else begin
          crlf_seen = 2'd0;
        end
      end
      PH_SIZE: begin
        nib = hex_nibble(b);
        if (nib[4]) begin
          if (chunk_size > (SIZE_MAX >> 4) || (chunk_size << 4) > SIZE_MAX - nib[3:0]) begin
            chunk_size = SIZE_MAX;
            clamped    = 1'b1;
          end else begin
            chunk_size = (chunk_size << 4) + nib[3:0];
          end
          digit_seen = 1'b1;
        end else if (b == CH_SP && !digit_seen) begin
          // leading space
        end else if (chunk_size == 0) begin
          close_message(it.in_last);
          return;
        end else begin
          data_left = chunk_size;
          phase     = (b == CH_LF) ? PH_DATA : PH_EXT;
        end
      end
      PH_EXT: begin
        if (b == CH_LF) phase = PH_DATA;
      end
      PH_DATA: begin
        put(b, 1'b0);
        data_left = data_left - 1;
        if (data_left == 0) begin
          phase     = PH_SKIP;
          pair_left = 2'd2;
        end
      end
      PH_SKIP: begin
        pair_left = pair_left - 2'd1;
        if (pair_left == 0) new_size_line();
      end
      default: begin
        // message already closed, drop until end of request
        if (it.in_last) clear_state();
        return;
      end
    endcase
    if (it.in_last) close_message(1'b1);
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    logic      bad;
    if (rst) begin
      clear_state();
      decoded_q.delete();
      failures = 0;
    end else begin
      if (tx_valid && tx_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected item byte %h last %b sat %b, expected none",
                   $time, tx_data.out_byte, tx_data.out_last, tx_data.size_saturated);
          failures++;
        end else begin
          want = decoded_q.pop_front();
          bad  = 1'b0;
          if (tx_data.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h",
                     $time, want.out_byte, tx_data.out_byte);
            bad = 1'b1;
          end
          if (tx_data.out_last !== want.out_last) begin
            $display("%0t: out_last expected %b actual %b",
                     $time, want.out_last, tx_data.out_last);
            bad = 1'b1;
          end
          if (tx_data.size_saturated !== want.size_saturated) begin
            $display("%0t: size_saturated expected %b actual %b",
                     $time, want.size_saturated, tx_data.size_saturated);
            bad = 1'b1;
          end
          if (bad) failures++;
        end
      end
      if (rx_valid && rx_ready) decode_byte(rx_data);
    end
    outstanding <= decoded_q.size();
  end

endmodule

@@ test/http_chunked_body_decoder_tb.sv @@
// testbench top for the chunked body decoder: request stimulus, idle phases and verdict
module http_chunked_body_decoder_tb;
  import hcbd_pkg::*;

  localparam int RANDOM_ITEMS = 460;
  localparam int CYCLE_LIMIT  = 200000;

  logic     clk;
  logic     rst;
  int       failures;
  int       outstanding;
  int       cycles = 0;
  int       sender_idle_pct;
  int       receiver_stall_pct;
  in_item_t request_q[$];

  hcbd_stream_if #(.T(in_item_t))  rx ();
  hcbd_stream_if #(.T(out_item_t)) tx ();

  http_chunked_body_decoder i_dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .tx  (tx)
  );

  http_chunked_body_decoder_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx.valid),
    .rx_ready    (rx.ready),
    .rx_data     (rx.data),
    .tx_valid    (tx.valid),
    .tx_ready    (tx.ready),
    .tx_data     (tx.data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    tx.ready <= !rst && ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** http_chunked_body_decoder: FAILED **");
      $finish;
    end
  end

  task automatic add_byte(input logic [7:0] b, input logic last = 1'b0);
    in_item_t it;
    it.in_byte = b;
    it.in_last = last;
    request_q.push_back(it);
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic mark_last();
    in_item_t it;
    it = request_q.pop_back();
    it.in_last = 1'b1;
    request_q.push_back(it);
  endtask

  task automatic add_hex(input logic [63:0] n);
    logic [3:0] nib;
    logic       started;
    int         i;
    started = 1'b0;
    repeat ($urandom_range(2)) add_text("0");
    for (i = 15; i >= 0; i--) begin
      nib = n[i*4 +: 4];
      if (nib != 0 || started || i == 0) begin
        started = 1'b1;
        if (nib < 10) add_byte(8'h30 + nib);
        else add_byte(($urandom_range(1) ? 8'h61 : 8'h41) + nib - 8'd10);
      end
    end
  endtask

  task automatic add_chunk();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) add_byte(CH_SP);
    add_hex(64'(len));
    case ($urandom_range(3))
      0: add_text(";name=val");
      1: add_text(" ext");
      default: ;
    endcase
    if ($urandom_range(4) == 0) add_byte(CH_LF);
    else add_text("\r\n");
    repeat (len) add_byte(8'($urandom_range(255)));
    if ($urandom_range(5) == 0) begin
      add_byte(8'($urandom_range(255)));
      add_byte(8'($urandom_range(255)));
    end else begin
      add_text("\r\n");
    end
  endtask

  task automatic add_request();
    int start;
    int kind;
    int cut;
    start = request_q.size();
    kind  = $urandom_range(99);
    if (kind < 8) begin
      // noise
      repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(12)) begin
        if ($urandom_range(3) == 0) add_byte(8'($urandom_range(255)));
        else add_byte(8'($urandom_range(32, 126)));
      end
      add_text("\r\n\r\n");
      repeat ($urandom_range(3)) add_chunk();
      if (kind < 16) begin
        case ($urandom_range(3))
          0: add_text("-3\r\n");
          1: add_text("+a\r\n");
          2: add_text("0x1f\r\n");
          default: add_text("\r\n");
        endcase
        if ($urandom_range(1)) add_text("junk");
      end else if (kind < 24) begin
        // large chunk size, clamped when over 32 bits; request ends inside its data
        add_text("1");
        repeat ($urandom_range(7, 9)) add_byte($urandom_range(1) ? "f" : "F");
        add_text("\r\n");
        repeat ($urandom_range(1, 5)) add_byte(8'($urandom_range(255)));
      end else begin
        add_text("0");
        if ($urandom_range(2) == 0) add_text(";end");
        add_text("\r\n");
        if ($urandom_range(2) == 0) add_text("Trailer: v\r\n");
        add_text("\r\n");
      end
    end
    if ($urandom_range(99) < 25) begin
      cut = $urandom_range(start, request_q.size() - 1);
      while (request_q.size() > cut + 1) void'(request_q.pop_back());
    end
    mark_last();
  endtask

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < sender_idle_pct) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid <= 1'b1;
    rx.data  <= it;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
  endtask

  initial begin
    int directed;
    int total;
    int k;
    rst                = 1'b1;
    rx.valid           = 1'b0;
    rx.data            = '0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;

    // request ends on its first header byte
    add_byte(8'h00, 1'b1);
    // leading space, space after digits, odd skip pair, no-digit line, bytes after end
    add_text("\r\n\r\n 2 \n");
    add_byte(8'h00);
    add_byte(8'hff);
    add_text("xyGq");
    add_byte("r", 1'b1);
    // oversized size, request ends in data
    add_text("\r\n\r\nFFFFFFFFF\n");
    add_byte(8'h5a, 1'b1);

    directed = request_q.size();
    while (request_q.size() < directed + RANDOM_ITEMS) add_request();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    total = request_q.size();
    for (k = 0; k < total; k++) begin
      case (k * 4 / total)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 75; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 75; end
        default: begin sender_idle_pct = 36; receiver_stall_pct = 36; end
      endcase
      send_item(request_q[k]);
    end
    rx.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (failures == 0) $display("** http_chunked_body_decoder: PASSED **");
    else $display("** http_chunked_body_decoder: FAILED **");
    $finish;
  end

endmodule
